/* src/apc_pkg.sv */
`timescale 1ns / 1ps
package apc_pkg;

  localparam int MAX_NODES_DEF  = 128;
  localparam int WORD_BITS      = 64;
  localparam int BIT_W          = 6;
  localparam logic [7:0] NODE_COUNT_RST = 8'd128;

  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE2,
    ST_ROOT_RD,
    ST_ROOT_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_NBR,
    ST_PUSH,
    ST_POP,
    ST_POP_RD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic set_en;
    logic clr_en;
    logic rd_en;
  } adj_ctl_t;

  typedef struct packed {
    logic found;
    logic done;
  } adj_stat_t;

  typedef struct packed {
    logic rec_we;
    logic rec_re;
    logic stk_we;
    logic stk_re;
  } node_ctl_t;

endpackage

/* src/apc_if.sv */
`timescale 1ns / 1ps
interface apc_item_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] node_a;
  logic [7:0] node_b;
  modport source (output valid, output action, output node_a, output node_b, input ready);
  modport sink (input valid, input action, input node_a, input node_b, output ready);
endinterface

interface apc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] cut_vertex_count;
  modport source (output valid, output cut_vertex_count, input ready);
  modport sink (input valid, input cut_vertex_count, output ready);
endinterface

interface apc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/articulation_point_counter.sv */
`timescale 1ns / 1ps
// Counts cut vertices of an undirected graph. Edge words are taken in the idle
// state. A valid edge makes one adjacency write per direction, in ST_IDLE and
// then in ST_EDGE2. An edge with an endpoint out of range, or a self loop, is
// dropped. An end word runs a depth-first search kept in a node-record memory
// and a cursor-stack memory. Each adjacency word is fetched in ST_SCAN_RD and
// checked in ST_SCAN_CHK, and the fetch is redone after every neighbor found.
// Each neighbor is checked in ST_NBR, and a tree edge adds the descend, pop
// and parent read-back steps (ST_PUSH, ST_POP, ST_POP_RD). Each node tried as
// a root is read in ST_ROOT_RD and checked in ST_ROOT_CHK. The count is then
// loaded into the output register, after any earlier count still held there
// has been taken. A clearing pass over every adjacency word then wipes the
// adjacency store and the node records; the same pass runs after reset. No
// input word is taken in ST_EDGE2, during the search, while waiting on the
// output register, or during the clearing pass.
module articulation_point_counter #(
  parameter int MAX_NODES = apc_pkg::MAX_NODES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  apc_item_if.sink      in_ch,
  apc_result_if.source  out_ch,
  apc_cfg_if.sink       cfg_ch
);
  import apc_pkg::*;

  localparam int NW        = $clog2(MAX_NODES);
  localparam int CW        = $clog2(MAX_NODES + 1);
  localparam int RW        = 2 * CW + NW + 1;
  localparam int ROW_WORDS = (MAX_NODES + WORD_BITS - 1) / WORD_BITS;
  localparam int WW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int DEPTH     = MAX_NODES << WW;
  localparam int AW        = NW + WW;

  state_t        state_r, state_nxt;
  logic [7:0]    node_count_r;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] b_r, b_nxt, a_r, a_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [NW-1:0] root_r, root_nxt, u_r, u_nxt, vt_r, vt_nxt, par_u_r, par_u_nxt;
  logic [CW-1:0] v_r, v_nxt, top_r, top_nxt, visit_r, visit_nxt;
  logic [CW-1:0] cut_total_r, cut_total_nxt, disc_u_r, disc_u_nxt, low_u_r, low_u_nxt;
  logic [1:0]    rcnt_r, rcnt_nxt;
  logic          cut_u_r, cut_u_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;

  logic [15:0]   n16, a16, b16;
  logic [CW-1:0] n, vis;
  logic          accept, edge_ok, mark;

  adj_ctl_t      adj_ctl;
  adj_stat_t     adj_stat;
  logic [NW-1:0] set_row, set_col, hit_node;
  logic [CW-1:0] next_cur;

  node_ctl_t     node_ctl;
  logic [NW-1:0] rec_waddr, rec_raddr, stk_waddr, stk_raddr;
  logic [RW-1:0] rec_wdata, rec_rdata;
  logic [CW-1:0] stk_wdata, stk_rdata;
  logic [CW-1:0] rd_disc, rd_low;
  logic [NW-1:0] rd_par;
  logic          rd_cut;

  apc_adj_store #(.MAX_NODES(MAX_NODES)) u_adj (
    .clk      (clk),
    .ctl      (adj_ctl),
    .set_row  (set_row),
    .set_col  (set_col),
    .clr_addr (idx_r),
    .rd_row   (u_r),
    .rd_cur   (v_r),
    .n        (n),
    .stat     (adj_stat),
    .hit_node (hit_node),
    .next_cur (next_cur)
  );

  apc_node_store #(.MAX_NODES(MAX_NODES)) u_node (
    .clk       (clk),
    .ctl       (node_ctl),
    .rec_waddr (rec_waddr),
    .rec_wdata (rec_wdata),
    .rec_raddr (rec_raddr),
    .rec_rdata (rec_rdata),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata)
  );

  assign rd_disc = rec_rdata[RW-1 -: CW];
  assign rd_low  = rec_rdata[RW-CW-1 -: CW];
  assign rd_par  = rec_rdata[NW:1];
  assign rd_cut  = rec_rdata[0];

  assign n16 = (16'(node_count_r) > 16'(MAX_NODES)) ? 16'(MAX_NODES) : 16'(node_count_r);
  assign n   = CW'(n16);
  assign a16 = 16'(in_ch.node_a);
  assign b16 = 16'(in_ch.node_b);
  assign edge_ok = (a16 >= 16'd1) && (b16 >= 16'd1) && (a16 <= n16) && (b16 <= n16)
                   && (a16 != b16);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.cut_vertex_count = out_data_r;

  assign vis  = visit_r + CW'(1);
  assign mark = (par_u_r != root_r) && (low_u_r >= rd_disc);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (idx_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.action == ACT_END) state_nxt = ST_ROOT_RD;
          else if (edge_ok)            state_nxt = ST_EDGE2;
        end
      end
      ST_EDGE2:    state_nxt = ST_IDLE;
      ST_ROOT_RD:  state_nxt = (r_r < n) ? ST_ROOT_CHK : ST_DONE;
      ST_ROOT_CHK: state_nxt = (rd_disc == '0) ? ST_SCAN_RD : ST_ROOT_RD;
      ST_SCAN_RD:  state_nxt = (v_r < n) ? ST_SCAN_CHK : ST_POP;
      ST_SCAN_CHK: begin
        if (adj_stat.found)     state_nxt = ST_NBR;
        else if (adj_stat.done) state_nxt = ST_POP;
        else                    state_nxt = ST_SCAN_RD;
      end
      ST_NBR:      state_nxt = (rd_disc == '0) ? ST_PUSH : ST_SCAN_RD;
      ST_PUSH:     state_nxt = ST_SCAN_RD;
      ST_POP:      state_nxt = (top_r == CW'(1)) ? ST_ROOT_RD : ST_POP_RD;
      ST_POP_RD:   state_nxt = ST_SCAN_RD;
      ST_DONE:     if (!out_valid_r) state_nxt = ST_CLEAR;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    r_nxt         = r_r;
    root_nxt      = root_r;
    u_nxt         = u_r;
    vt_nxt        = vt_r;
    par_u_nxt     = par_u_r;
    v_nxt         = v_r;
    top_nxt       = top_r;
    visit_nxt     = visit_r;
    cut_total_nxt = cut_total_r;
    disc_u_nxt    = disc_u_r;
    low_u_nxt     = low_u_r;
    rcnt_nxt      = rcnt_r;
    cut_u_nxt     = cut_u_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    adj_ctl       = '0;
    node_ctl      = '0;
    set_row       = a_r;
    set_col       = b_r;
    rec_waddr     = u_r;
    rec_wdata     = {disc_u_r, low_u_r, par_u_r, cut_u_r};
    rec_raddr     = NW'(r_r);
    stk_waddr     = NW'(top_r - CW'(1));
    stk_wdata     = v_r;
    stk_raddr     = NW'(top_r - CW'(2));

    if (out_ch.valid && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        adj_ctl.clr_en  = 1'b1;
        node_ctl.rec_we = (idx_r < AW'(MAX_NODES));
        rec_waddr       = NW'(idx_r);
        rec_wdata       = '0;
        idx_nxt         = idx_r + AW'(1);
        visit_nxt       = '0;
        cut_total_nxt   = '0;
      end
      ST_IDLE: begin
        if (accept && in_ch.action == ACT_EDGE && edge_ok) begin
          adj_ctl.set_en = 1'b1;
          set_row        = NW'(a16 - 16'd1);
          set_col        = NW'(b16 - 16'd1);
          a_nxt          = NW'(a16 - 16'd1);
          b_nxt          = NW'(b16 - 16'd1);
        end
        if (accept && in_ch.action == ACT_END) r_nxt = '0;
      end
      ST_EDGE2: begin
        adj_ctl.set_en = 1'b1;
        set_row        = b_r;
        set_col        = a_r;
      end
      ST_ROOT_RD: begin
        node_ctl.rec_re = (r_r < n);
      end
      ST_ROOT_CHK: begin
        if (rd_disc == '0) begin
          node_ctl.rec_we = 1'b1;
          rec_waddr       = NW'(r_r);
          rec_wdata       = {vis, vis, NW'(r_r), 1'b0};
          visit_nxt       = vis;
          root_nxt        = NW'(r_r);
          u_nxt           = NW'(r_r);
          v_nxt           = '0;
          top_nxt         = CW'(1);
          rcnt_nxt        = '0;
          disc_u_nxt      = vis;
          low_u_nxt       = vis;
          par_u_nxt       = NW'(r_r);
          cut_u_nxt       = 1'b0;
        end else begin
          r_nxt = r_r + CW'(1);
        end
      end
      ST_SCAN_RD: begin
        adj_ctl.rd_en = (v_r < n);
      end
      ST_SCAN_CHK: begin
        if (adj_stat.found) begin
          v_nxt           = CW'(hit_node) + CW'(1);
          vt_nxt          = hit_node;
          node_ctl.rec_re = 1'b1;
          rec_raddr       = hit_node;
        end else if (!adj_stat.done) begin
          v_nxt = next_cur;
        end
      end
      ST_NBR: begin
        if (rd_disc == '0) begin
          // park the current node and its cursor before descending
          node_ctl.rec_we = 1'b1;
          node_ctl.stk_we = 1'b1;
        end else if (vt_r != par_u_r && rd_disc < low_u_r) begin
          low_u_nxt = rd_disc;
        end
      end
      ST_PUSH: begin
        node_ctl.rec_we = 1'b1;
        rec_waddr       = vt_r;
        rec_wdata       = {vis, vis, u_r, 1'b0};
        top_nxt         = top_r + CW'(1);
        if (u_r == root_r && rcnt_r != 2'd3) rcnt_nxt = rcnt_r + 2'd1;
        visit_nxt       = vis;
        u_nxt           = vt_r;
        v_nxt           = '0;
        disc_u_nxt      = vis;
        low_u_nxt       = vis;
        par_u_nxt       = u_r;
        cut_u_nxt       = 1'b0;
      end
      ST_POP: begin
        top_nxt = top_r - CW'(1);
        if (top_r == CW'(1)) begin
          if (rcnt_r >= 2'd2) cut_total_nxt = cut_total_r + CW'(1);
          r_nxt = r_r + CW'(1);
        end else begin
          node_ctl.rec_we = 1'b1;
          node_ctl.rec_re = 1'b1;
          node_ctl.stk_re = 1'b1;
          rec_raddr       = par_u_r;
        end
      end
      ST_POP_RD: begin
        cut_u_nxt = rd_cut | mark;
        if (mark && !rd_cut) cut_total_nxt = cut_total_r + CW'(1);
        low_u_nxt  = (low_u_r < rd_low) ? low_u_r : rd_low;
        disc_u_nxt = rd_disc;
        par_u_nxt  = rd_par;
        u_nxt      = par_u_r;
        v_nxt      = stk_rdata;
      end
      ST_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 8'(cut_total_r);
          idx_nxt       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      node_count_r <= NODE_COUNT_RST;
      idx_r        <= '0;
      r_r          <= '0;
      top_r        <= '0;
      visit_r      <= '0;
      cut_total_r  <= '0;
      rcnt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      r_r          <= r_nxt;
      top_r        <= top_nxt;
      visit_r      <= visit_nxt;
      cut_total_r  <= cut_total_nxt;
      rcnt_r       <= rcnt_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_ch.valid) node_count_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    root_r     <= root_nxt;
    u_r        <= u_nxt;
    vt_r       <= vt_nxt;
    par_u_r    <= par_u_nxt;
    v_r        <= v_nxt;
    disc_u_r   <= disc_u_nxt;
    low_u_r    <= low_u_nxt;
    cut_u_r    <= cut_u_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* src/apc_adj_store.sv */
`timescale 1ns / 1ps
module apc_adj_store #(
  parameter int MAX_NODES = apc_pkg::MAX_NODES_DEF
) (
  input  logic                              clk,
  input  apc_pkg::adj_ctl_t                 ctl,
  input  logic [$clog2(MAX_NODES)-1:0]      set_row,
  input  logic [$clog2(MAX_NODES)-1:0]      set_col,
  input  logic [$clog2(MAX_NODES)+((((MAX_NODES+63)/64)>1)?$clog2((MAX_NODES+63)/64):1)-1:0]
                                            clr_addr,
  input  logic [$clog2(MAX_NODES)-1:0]      rd_row,
  input  logic [$clog2(MAX_NODES+1)-1:0]    rd_cur,
  input  logic [$clog2(MAX_NODES+1)-1:0]    n,
  output apc_pkg::adj_stat_t                stat,
  output logic [$clog2(MAX_NODES)-1:0]      hit_node,
  output logic [$clog2(MAX_NODES+1)-1:0]    next_cur
);
  import apc_pkg::*;

  localparam int NW        = $clog2(MAX_NODES);
  localparam int CW        = $clog2(MAX_NODES + 1);
  localparam int ROW_WORDS = (MAX_NODES + WORD_BITS - 1) / WORD_BITS;
  localparam int WW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int DEPTH     = MAX_NODES << WW;

  logic [WORD_BITS-1:0] adj_mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [CW-1:0]        cur_r;

  logic [15:0] set16, rd16, cur16, base16, hit16, next16, n16;
  logic [WORD_BITS-1:0] masked;
  logic                 any;
  logic [BIT_W-1:0]     pos;

  assign set16 = 16'(set_col);
  assign rd16  = 16'(rd_cur);

  always_ff @(posedge clk) begin
    if (ctl.clr_en) begin
      adj_mem[clr_addr] <= '0;
    end else if (ctl.set_en) begin
      adj_mem[{set_row, WW'(set16 >> BIT_W)}][set16[BIT_W-1:0]] <= 1'b1;
    end
    if (ctl.rd_en) begin
      rd_data_r <= adj_mem[{rd_row, WW'(rd16 >> BIT_W)}];
      cur_r     <= rd_cur;
    end
  end

  // lowest neighbor at or above the cursor within the fetched word
  always_comb begin
    cur16  = 16'(cur_r);
    masked = rd_data_r & ({WORD_BITS{1'b1}} << cur16[BIT_W-1:0]);
    any    = 1'b0;
    pos    = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) begin
        any = 1'b1;
        pos = BIT_W'(i);
      end
    end
    base16 = {cur16[15:BIT_W], {BIT_W{1'b0}}};
    hit16  = base16 + 16'(pos);
    next16 = base16 + 16'(WORD_BITS);
    n16    = 16'(n);
    stat.found = any && (hit16 < n16);
    stat.done  = (any && (hit16 >= n16)) || (!any && (next16 >= n16));
    hit_node   = NW'(hit16);
    next_cur   = CW'(next16);
  end

endmodule

/* src/apc_node_store.sv */
`timescale 1ns / 1ps
module apc_node_store #(
  parameter int MAX_NODES = apc_pkg::MAX_NODES_DEF
) (
  input  logic                                               clk,
  input  apc_pkg::node_ctl_t                                 ctl,
  input  logic [$clog2(MAX_NODES)-1:0]                       rec_waddr,
  input  logic [2*$clog2(MAX_NODES+1)+$clog2(MAX_NODES):0]   rec_wdata,
  input  logic [$clog2(MAX_NODES)-1:0]                       rec_raddr,
  output logic [2*$clog2(MAX_NODES+1)+$clog2(MAX_NODES):0]   rec_rdata,
  input  logic [$clog2(MAX_NODES)-1:0]                       stk_waddr,
  input  logic [$clog2(MAX_NODES+1)-1:0]                     stk_wdata,
  input  logic [$clog2(MAX_NODES)-1:0]                       stk_raddr,
  output logic [$clog2(MAX_NODES+1)-1:0]                     stk_rdata
);
  import apc_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int RW = 2 * CW + NW + 1;

  // node record: discovery, low link, parent, cut mark
  logic [RW-1:0] rec_mem [MAX_NODES];
  // per-level neighbor cursor of the search stack
  logic [CW-1:0] stk_mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (ctl.rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (ctl.rec_re) begin
      rec_rdata <= rec_mem[rec_raddr];
    end
    if (ctl.stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (ctl.stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

endmodule
